// File: hw/rtl/tracker_pattern_cell_unpacker_defines.svh
// Assertion macros for the pattern cell unpacker.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef TRACKER_PATTERN_CELL_UNPACKER_DEFINES_SVH
`define TRACKER_PATTERN_CELL_UNPACKER_DEFINES_SVH

// same-cycle implication
`define TPCU_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TPCU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/tpcu_pkg.sv
// Package for the pattern cell unpacker: limits, effect codes, cell type and tables.
// No dependencies.
`default_nettype none

package tpcu_pkg;

  localparam int MAX_CHANNELS = 32;
  localparam int MAX_ROWS     = 256;
  localparam int CH_LIMIT     = (MAX_CHANNELS < 32) ? MAX_CHANNELS : 32;
  localparam int ROW_LIMIT    = (MAX_ROWS < 256) ? MAX_ROWS : 256;

  localparam logic [7:0] EMPTY    = 8'hFF;
  localparam logic [7:0] KEY_OFF  = 8'hFE;
  localparam logic [7:0] NOTE_OFF = 8'd97;

  // configuration register indexes
  localparam logic CFG_CHANNELS = 1'b0;
  localparam logic CFG_ROWS     = 1'b1;

  // packed effect codes
  localparam logic [7:0] FX_ARPEGGIO    = 8'h00;
  localparam logic [7:0] FX_PORTA_UP    = 8'h01;
  localparam logic [7:0] FX_PORTA_DOWN  = 8'h02;
  localparam logic [7:0] FX_TONE_PORTA  = 8'h03;
  localparam logic [7:0] FX_VIBRATO     = 8'h04;
  localparam logic [7:0] FX_TONE_VOL    = 8'h05;
  localparam logic [7:0] FX_VIB_VOL     = 8'h06;
  localparam logic [7:0] FX_TREMOLO     = 8'h07;
  localparam logic [7:0] FX_PANNING     = 8'h08;
  localparam logic [7:0] FX_OFFSET      = 8'h09;
  localparam logic [7:0] FX_VOL_SLIDE   = 8'h0A;
  localparam logic [7:0] FX_JUMP        = 8'h0B;
  localparam logic [7:0] FX_BREAK       = 8'h0D;
  localparam logic [7:0] FX_EXTENDED    = 8'h0E;
  localparam logic [7:0] FX_SPEED       = 8'h0F;
  localparam logic [7:0] FX_GLOBAL_VOL  = 8'h10;
  localparam logic [7:0] FX_GLOBAL_SLIDE = 8'h11;
  localparam logic [7:0] FX_KEY_OFF     = 8'h14;
  localparam logic [7:0] FX_PAN_SLIDE   = 8'h19;
  localparam logic [7:0] FX_RETRIGGER   = 8'h1B;
  localparam logic [7:0] FX_TREMOR      = 8'h1D;

  // extended effect subcodes (high nibble)
  localparam logic [3:0] EXT_FINE_UP       = 4'h1;
  localparam logic [3:0] EXT_FINE_DOWN     = 4'h2;
  localparam logic [3:0] EXT_RETRIGGER     = 4'h9;
  localparam logic [3:0] EXT_FINE_VOL_UP   = 4'hA;
  localparam logic [3:0] EXT_FINE_VOL_DOWN = 4'hB;
  localparam logic [3:0] EXT_ROW_DELAY     = 4'hE;

  // letter-coded output commands
  localparam logic [7:0] CMD_A = 8'd0;
  localparam logic [7:0] CMD_B = 8'd1;
  localparam logic [7:0] CMD_C = 8'd2;
  localparam logic [7:0] CMD_D = 8'd3;
  localparam logic [7:0] CMD_E = 8'd4;
  localparam logic [7:0] CMD_F = 8'd5;
  localparam logic [7:0] CMD_G = 8'd6;
  localparam logic [7:0] CMD_H = 8'd7;
  localparam logic [7:0] CMD_I = 8'd8;
  localparam logic [7:0] CMD_J = 8'd9;
  localparam logic [7:0] CMD_K = 8'd10;
  localparam logic [7:0] CMD_L = 8'd11;
  localparam logic [7:0] CMD_O = 8'd14;
  localparam logic [7:0] CMD_P = 8'd15;
  localparam logic [7:0] CMD_Q = 8'd16;
  localparam logic [7:0] CMD_R = 8'd17;
  localparam logic [7:0] CMD_S = 8'd18;
  localparam logic [7:0] CMD_T = 8'd19;
  localparam logic [7:0] CMD_V = 8'd21;
  localparam logic [7:0] CMD_W = 8'd22;
  localparam logic [7:0] CMD_X = 8'd23;

  typedef struct packed {
    logic [7:0] note;
    logic [7:0] instrument;
    logic [7:0] volume;
    logic [7:0] command;
    logic [7:0] parameter_b;
    logic [4:0] channel;
    logic [7:0] row;
    logic       last;
  } cell_t;

  // lo*65/15
  function automatic logic [7:0] pan_scale(input logic [3:0] lo);
    logic [7:0] r;
    case (lo)
      4'd0:    r = 8'd0;
      4'd1:    r = 8'd4;
      4'd2:    r = 8'd8;
      4'd3:    r = 8'd13;
      4'd4:    r = 8'd17;
      4'd5:    r = 8'd21;
      4'd6:    r = 8'd26;
      4'd7:    r = 8'd30;
      4'd8:    r = 8'd34;
      4'd9:    r = 8'd39;
      4'd10:   r = 8'd43;
      4'd11:   r = 8'd47;
      4'd12:   r = 8'd52;
      4'd13:   r = 8'd56;
      4'd14:   r = 8'd60;
      default: r = 8'd65;
    endcase
    return r;
  endfunction

  // lo*9/15
  function automatic logic [7:0] porta_scale(input logic [3:0] lo);
    logic [7:0] r;
    case (lo)
      4'd0, 4'd1:   r = 8'd0;
      4'd2, 4'd3:   r = 8'd1;
      4'd4:         r = 8'd2;
      4'd5, 4'd6:   r = 8'd3;
      4'd7, 4'd8:   r = 8'd4;
      4'd9:         r = 8'd5;
      4'd10, 4'd11: r = 8'd6;
      4'd12, 4'd13: r = 8'd7;
      4'd14:        r = 8'd8;
      default:      r = 8'd9;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/tpcu_ifs.sv
// Stream interfaces of the pattern cell unpacker: packed byte input, cell output.
// No dependencies.
`default_nettype none

interface tpcu_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] stream_byte;
  modport source (output valid, output stream_byte, input ready);
  modport sink   (input valid, input stream_byte, output ready);
endinterface

interface tpcu_cell_if;
  logic       valid;
  logic       ready;
  logic [7:0] note_out;
  logic [7:0] instrument_out;
  logic [7:0] volume_out;
  logic [7:0] command_out;
  logic [7:0] parameter_out;
  logic [4:0] channel_index;
  logic [7:0] row_index;
  logic       last_cell;
  modport source (output valid, output note_out, output instrument_out, output volume_out,
                  output command_out, output parameter_out, output channel_index,
                  output row_index, output last_cell, input ready);
  modport sink   (input valid, input note_out, input instrument_out, input volume_out,
                  input command_out, input parameter_out, input channel_index,
                  input row_index, input last_cell, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/tpcu_parse.sv
// Byte parser: field latching, position counters, config registers, raw cell register.
// Depends on tpcu_pkg, tpcu_ifs and the assertion macro header.
`default_nettype none
`include "tracker_pattern_cell_unpacker_defines.svh"

module tpcu_parse (
  input  wire logic           clk,
  input  wire logic           rst,
  tpcu_byte_if.sink           pattern,
  input  wire logic           cfg_we,
  input  wire logic           cfg_index,
  input  wire logic [8:0]     cfg_data,
  output tpcu_pkg::cell_t     raw,
  output logic                cell_valid,
  input  wire logic           down_ready
);

  logic [5:0] channel_count;
  logic [8:0] row_count;
  logic [4:0] pending_flags, pending_flags_next;
  logic       cell_open;
  logic [7:0] raw_note, raw_note_next;
  logic [7:0] raw_instrument, raw_instrument_next;
  logic [7:0] raw_volume, raw_volume_next;
  logic [7:0] raw_command, raw_command_next;
  logic [7:0] raw_parameter, raw_parameter_next;
  logic [4:0] channel_counter;
  logic [7:0] row_counter;
  logic [5:0] eff_channels;
  logic [8:0] eff_rows;
  logic       last_ch, last_row, accept, done;
  logic [7:0] b;

  assign b = pattern.stream_byte;
  assign pattern.ready = !cell_valid || down_ready;
  assign accept = pattern.valid && pattern.ready;

  always_comb begin
    raw_note_next       = raw_note;
    raw_instrument_next = raw_instrument;
    raw_volume_next     = raw_volume;
    raw_command_next    = raw_command;
    raw_parameter_next  = raw_parameter;
    pending_flags_next  = pending_flags;
    if (!cell_open) begin
      raw_note_next       = tpcu_pkg::EMPTY;
      raw_instrument_next = tpcu_pkg::EMPTY;
      raw_volume_next     = tpcu_pkg::EMPTY;
      raw_command_next    = tpcu_pkg::EMPTY;
      raw_parameter_next  = 8'd0;
      if (!b[7]) begin
        raw_note_next      = b;
        pending_flags_next = 5'h1E;
      end else begin
        pending_flags_next = b[4:0];
      end
    end else if (pending_flags[0]) begin
      raw_note_next      = b;
      pending_flags_next = pending_flags & 5'h1E;
    end else if (pending_flags[1]) begin
      raw_instrument_next = b;
      pending_flags_next  = pending_flags & 5'h1C;
    end else if (pending_flags[2]) begin
      raw_volume_next    = b;
      pending_flags_next = pending_flags & 5'h18;
    end else if (pending_flags[3]) begin
      raw_command_next   = b;
      pending_flags_next = pending_flags & 5'h10;
    end else begin
      raw_parameter_next = b;
      pending_flags_next = 5'd0;
    end
  end

  assign done = (pending_flags_next == 5'd0);

  always_comb begin
    if (channel_count == 6'd0) begin
      eff_channels = 6'd1;
    end else if (channel_count > 6'(tpcu_pkg::CH_LIMIT)) begin
      eff_channels = 6'(tpcu_pkg::CH_LIMIT);
    end else begin
      eff_channels = channel_count;
    end
    if (row_count == 9'd0) begin
      eff_rows = 9'd1;
    end else if (row_count > 9'(tpcu_pkg::ROW_LIMIT)) begin
      eff_rows = 9'(tpcu_pkg::ROW_LIMIT);
    end else begin
      eff_rows = row_count;
    end
  end

  assign last_ch  = ({1'b0, channel_counter} + 6'd1) >= eff_channels;
  assign last_row = ({1'b0, row_counter} + 9'd1) >= eff_rows;

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_count   <= 6'd8;
      row_count       <= 9'd64;
      pending_flags   <= 5'd0;
      cell_open       <= 1'b0;
      channel_counter <= 5'd0;
      row_counter     <= 8'd0;
      cell_valid      <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          tpcu_pkg::CFG_CHANNELS: channel_count <= cfg_data[5:0];
          tpcu_pkg::CFG_ROWS:     row_count     <= cfg_data;
          default: ;
        endcase
      end
      if (accept) begin
        pending_flags <= pending_flags_next;
        cell_open     <= !done;
      end
      if (accept && done) begin
        cell_valid <= 1'b1;
        if (last_ch) begin
          channel_counter <= 5'd0;
          row_counter     <= last_row ? 8'd0 : row_counter + 8'd1;
        end else begin
          channel_counter <= channel_counter + 5'd1;
        end
      end else if (down_ready) begin
        cell_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      raw_note       <= raw_note_next;
      raw_instrument <= raw_instrument_next;
      raw_volume     <= raw_volume_next;
      raw_command    <= raw_command_next;
      raw_parameter  <= raw_parameter_next;
    end
    if (accept && done) begin
      raw.note        <= raw_note_next;
      raw.instrument  <= raw_instrument_next;
      raw.volume      <= raw_volume_next;
      raw.command     <= raw_command_next;
      raw.parameter_b <= raw_parameter_next;
      raw.channel     <= channel_counter;
      raw.row         <= row_counter;
      raw.last        <= last_ch && last_row;
    end
  end

  `TPCU_ASSERT_NEXT(a_emit_on_close, clk, rst, accept, cell_valid != cell_open,
                    "cell close and emitted cell disagree")
  `TPCU_ASSERT_NEXT(a_cell_hold, clk, rst, cell_valid && !down_ready,
                    cell_valid && $stable(raw), "raw cell changed while stalled")
  `TPCU_ASSERT_NOW(a_open_pending, clk, rst, cell_open, pending_flags != 5'd0,
                   "open cell with nothing pending")

endmodule

`default_nettype wire

// File: hw/rtl/tpcu_convert.sv
// Cell converter: note, instrument, volume column and effect translation into the
// output register. Depends on tpcu_pkg, tpcu_ifs and the assertion macro header.
`default_nettype none
`include "tracker_pattern_cell_unpacker_defines.svh"

module tpcu_convert (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire tpcu_pkg::cell_t raw,
  input  wire logic            cell_valid,
  output logic                 down_ready,
  tpcu_cell_if.source          result
);

  tpcu_pkg::cell_t conv, out_reg;
  logic            out_valid;
  logic [3:0]      vhi, vlo, plo;
  logic [3:0]      vclip;

  assign vhi   = raw.volume[7:4];
  assign vlo   = raw.volume[3:0];
  assign plo   = raw.parameter_b[3:0];
  assign vclip = (vlo > 4'd9) ? 4'd9 : vlo;

  always_comb begin
    conv = raw;
    conv.note = (raw.note == tpcu_pkg::NOTE_OFF) ? tpcu_pkg::KEY_OFF : raw.note;
    if (raw.instrument != tpcu_pkg::EMPTY) begin
      conv.instrument = (raw.instrument >= 8'd1 && raw.instrument < 8'd100) ?
                        raw.instrument - 8'd1 : tpcu_pkg::EMPTY;
    end

    if (raw.volume == tpcu_pkg::EMPTY) begin
      conv.volume = tpcu_pkg::EMPTY;
    end else begin
      case (vhi) inside
        4'h0:          conv.volume = raw.volume;
        [4'h1:4'h4]:   conv.volume = raw.volume - 8'h10;
        4'h6:          conv.volume = {4'd0, vclip} + 8'd95;
        4'h7:          conv.volume = {4'd0, vclip} + 8'd85;
        4'h8:          conv.volume = {4'd0, vclip} + 8'd75;
        4'h9:          conv.volume = {4'd0, vclip} + 8'd65;
        4'hB:          conv.volume = {4'd0, vclip} + 8'd203;
        4'hC:          conv.volume = 8'd128 + tpcu_pkg::pan_scale(vlo);
        4'hF:          conv.volume = 8'd193 + tpcu_pkg::porta_scale(vlo);
        default:       conv.volume = tpcu_pkg::EMPTY;
      endcase
    end

    if (raw.command != tpcu_pkg::EMPTY) begin
      case (raw.command)
        tpcu_pkg::FX_ARPEGGIO:     conv.command = tpcu_pkg::CMD_J;
        tpcu_pkg::FX_PORTA_UP:     conv.command = tpcu_pkg::CMD_F;
        tpcu_pkg::FX_PORTA_DOWN:   conv.command = tpcu_pkg::CMD_E;
        tpcu_pkg::FX_TONE_PORTA:   conv.command = tpcu_pkg::CMD_G;
        tpcu_pkg::FX_VIBRATO:      conv.command = tpcu_pkg::CMD_H;
        tpcu_pkg::FX_TONE_VOL:     conv.command = tpcu_pkg::CMD_L;
        tpcu_pkg::FX_VIB_VOL:      conv.command = tpcu_pkg::CMD_K;
        tpcu_pkg::FX_TREMOLO:      conv.command = tpcu_pkg::CMD_R;
        tpcu_pkg::FX_PANNING:      conv.command = tpcu_pkg::CMD_X;
        tpcu_pkg::FX_OFFSET:       conv.command = tpcu_pkg::CMD_O;
        tpcu_pkg::FX_VOL_SLIDE:    conv.command = tpcu_pkg::CMD_D;
        tpcu_pkg::FX_JUMP:         conv.command = tpcu_pkg::CMD_B;
        tpcu_pkg::FX_BREAK:        conv.command = tpcu_pkg::CMD_C;
        tpcu_pkg::FX_EXTENDED: begin
          conv.command = tpcu_pkg::CMD_S;
          case (raw.parameter_b[7:4])
            tpcu_pkg::EXT_FINE_UP, tpcu_pkg::EXT_FINE_DOWN, tpcu_pkg::EXT_RETRIGGER,
            tpcu_pkg::EXT_FINE_VOL_UP, tpcu_pkg::EXT_FINE_VOL_DOWN: begin
              if (plo == 4'd0) begin
                conv.command     = tpcu_pkg::EMPTY;
                conv.parameter_b = 8'd0;
              end else begin
                case (raw.parameter_b[7:4])
                  tpcu_pkg::EXT_FINE_UP: begin
                    conv.command     = tpcu_pkg::CMD_F;
                    conv.parameter_b = {4'hF, plo};
                  end
                  tpcu_pkg::EXT_FINE_DOWN: begin
                    conv.command     = tpcu_pkg::CMD_E;
                    conv.parameter_b = {4'hF, plo};
                  end
                  tpcu_pkg::EXT_RETRIGGER: begin
                    conv.command     = tpcu_pkg::CMD_Q;
                    conv.parameter_b = {4'h0, plo};
                  end
                  tpcu_pkg::EXT_FINE_VOL_UP: begin
                    conv.command     = tpcu_pkg::CMD_D;
                    conv.parameter_b = {plo, 4'hF};
                  end
                  default: begin
                    conv.command     = tpcu_pkg::CMD_D;
                    conv.parameter_b = {4'hF, plo};
                  end
                endcase
              end
            end
            tpcu_pkg::EXT_ROW_DELAY: conv.parameter_b = {4'hB, plo};
            default: ;
          endcase
        end
        tpcu_pkg::FX_SPEED:
          conv.command = (raw.parameter_b < 8'd32) ? tpcu_pkg::CMD_A : tpcu_pkg::CMD_T;
        tpcu_pkg::FX_GLOBAL_VOL:   conv.command = tpcu_pkg::CMD_V;
        tpcu_pkg::FX_GLOBAL_SLIDE: conv.command = tpcu_pkg::CMD_W;
        tpcu_pkg::FX_KEY_OFF: begin
          if (conv.note == tpcu_pkg::EMPTY) begin
            conv.note = tpcu_pkg::KEY_OFF;
          end
          conv.command = tpcu_pkg::EMPTY;
        end
        tpcu_pkg::FX_PAN_SLIDE:    conv.command = tpcu_pkg::CMD_P;
        tpcu_pkg::FX_RETRIGGER:    conv.command = tpcu_pkg::CMD_Q;
        tpcu_pkg::FX_TREMOR:       conv.command = tpcu_pkg::CMD_I;
        default:                   conv.command = tpcu_pkg::EMPTY;
      endcase
    end
  end

  assign down_ready = !out_valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (down_ready) begin
      out_valid <= cell_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (down_ready && cell_valid) begin
      out_reg <= conv;
    end
  end

  assign result.valid          = out_valid;
  assign result.note_out       = out_reg.note;
  assign result.instrument_out = out_reg.instrument;
  assign result.volume_out     = out_reg.volume;
  assign result.command_out    = out_reg.command;
  assign result.parameter_out  = out_reg.parameter_b;
  assign result.channel_index  = out_reg.channel;
  assign result.row_index      = out_reg.row;
  assign result.last_cell      = out_reg.last;

  `TPCU_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !result.ready,
                    out_valid && $stable(out_reg), "result changed while stalled")
  `TPCU_ASSERT_NOW(a_no_raw_keyoff, clk, rst, out_valid, out_reg.note != tpcu_pkg::NOTE_OFF,
                   "key-off note left unconverted")
  `TPCU_ASSERT_NOW(a_inst_range, clk, rst, out_valid,
                   (out_reg.instrument < 8'd99) || (out_reg.instrument == tpcu_pkg::EMPTY),
                   "instrument out of range")

endmodule

`default_nettype wire

// File: hw/rtl/tracker_pattern_cell_unpacker.sv
// Top level of the pattern cell unpacker: parser stage and converter stage.
// Depends on tpcu_pkg, tpcu_ifs, tpcu_parse and tpcu_convert.
//
//  port      role      transfer
//  pattern   sink      one packed byte
//  result    source    one converted cell with channel, row, last flag
//  cfg_*     write     channel_count (index 0), row_count (index 1)
//
// One byte is taken every cycle while pattern.ready is high; the cell completed by a
// final byte passes the raw cell register, then the result register, before it is
// on result. Synchronous reset clears counters, cell state and valids, and loads
// 8 channels and 64 rows. With both registers full, result.ready low drops
// pattern.ready in the same cycle.
`default_nettype none

module tracker_pattern_cell_unpacker (
  input  wire logic       clk,
  input  wire logic       rst,
  tpcu_byte_if.sink       pattern,
  tpcu_cell_if.source     result,
  input  wire logic       cfg_we,
  input  wire logic       cfg_index,
  input  wire logic [8:0] cfg_data
);

  tpcu_pkg::cell_t raw_cell;
  logic            raw_valid;
  logic            raw_ready;

  tpcu_parse u_parse (
    .clk        (clk),
    .rst        (rst),
    .pattern    (pattern),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .raw        (raw_cell),
    .cell_valid (raw_valid),
    .down_ready (raw_ready)
  );

  tpcu_convert u_convert (
    .clk        (clk),
    .rst        (rst),
    .raw        (raw_cell),
    .cell_valid (raw_valid),
    .down_ready (raw_ready),
    .result     (result)
  );

endmodule

`default_nettype wire

// File: dv/tb.sv
// Self-checking bench for tracker_pattern_cell_unpacker: packed bytes go in, converted
// cells are predicted in the bench and compared field by field as they come out.
// Depends on tpcu_pkg, tpcu_ifs and the unpacker RTL.
`default_nettype none

module tb;
  import tpcu_pkg::*;

  localparam int CLK_PERIOD     = 12;
  localparam int TIMEOUT_CYCLES = 400000;
  localparam int PHASES         = 8;
  localparam int PHASE_BYTES    = 160;
  localparam int SETTLE_CYCLES  = 4;
  localparam int MAX_PRINTS     = 60;
  localparam logic [7:0] FX_SET_VOLUME = 8'h0C;

  typedef struct {
    logic [7:0] b;
    bit         typed;
    cell_t      want;
  } dir_step_t;

  logic       clk;
  logic       rst;
  logic       cfg_we;
  logic       cfg_index;
  logic [8:0] cfg_data;

  tpcu_byte_if pattern_if ();
  tpcu_cell_if cell_if ();

  tracker_pattern_cell_unpacker dut (
    .clk       (clk),
    .rst       (rst),
    .pattern   (pattern_if),
    .result    (cell_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // predictor state
  logic [5:0] chan_reg = 6'd8;
  logic [8:0] row_reg  = 9'd64;
  logic [4:0] want_flags = 5'd0;
  bit         cell_busy = 1'b0;
  logic [7:0] f_note = EMPTY, f_inst = EMPTY, f_vol = EMPTY, f_cmd = EMPTY, f_par = 8'd0;
  logic [4:0] ch_pos = 5'd0;
  logic [7:0] row_pos = 8'd0;

  cell_t     cells_due[$];
  dir_step_t dir_plan[$];

  int mismatches = 0;
  int bytes_sent = 0;
  int cells_seen = 0;
  int pattern_ends = 0;
  int idle_pct = 0;
  int stall_pct = 0;

  logic [7:0] fx_codes[21] = '{FX_ARPEGGIO, FX_PORTA_UP, FX_PORTA_DOWN, FX_TONE_PORTA,
    FX_VIBRATO, FX_TONE_VOL, FX_VIB_VOL, FX_TREMOLO, FX_PANNING, FX_OFFSET, FX_VOL_SLIDE,
    FX_JUMP, FX_BREAK, FX_EXTENDED, FX_SPEED, FX_GLOBAL_VOL, FX_GLOBAL_SLIDE, FX_KEY_OFF,
    FX_PAN_SLIDE, FX_RETRIGGER, FX_TREMOR};
  logic [3:0] ext_codes[6] = '{EXT_FINE_UP, EXT_FINE_DOWN, EXT_RETRIGGER, EXT_FINE_VOL_UP,
    EXT_FINE_VOL_DOWN, EXT_ROW_DELAY};

  logic [8:0] ph_chans[PHASES] = '{9'd1, 9'd32, 9'd0, 9'h1FF, 9'd3, 9'd2, 9'd7, 9'h1C5};
  logic [8:0] ph_rows[PHASES]  = '{9'd1, 9'd256, 9'd0, 9'd511, 9'd5, 9'd300, 9'd3, 9'd2};
  int         ph_idle[PHASES]  = '{0, 58, 0, 19, 58, 0, 0, 19};
  int         ph_stall[PHASES] = '{0, 0, 58, 19, 0, 58, 0, 19};

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  initial begin
    #(CLK_PERIOD * TIMEOUT_CYCLES);
    $display("run timed out with %0d cells still due", cells_due.size());
    $display("CHECK FAILED");
    $finish;
  end

  // Accepts one packed byte into the predictor; returns 1 with the cell it completes.
  function automatic bit unpack_byte(input logic [7:0] b, output cell_t c);
    int chans, nrows, vclip, lo_v;
    logic [7:0] note, inst, vol, cmd, par;
    logic [3:0] lo, hi;
    bit last_ch, last_row;
    if (!cell_busy) begin
      f_note = EMPTY;
      f_inst = EMPTY;
      f_vol  = EMPTY;
      f_cmd  = EMPTY;
      f_par  = 8'd0;
      if (!b[7]) begin
        f_note = b;
        want_flags = 5'h1E;
      end else begin
        want_flags = b[4:0];
      end
    end else if (want_flags[0]) begin
      f_note = b;
      want_flags[0] = 1'b0;
    end else if (want_flags[1]) begin
      f_inst = b;
      want_flags[1] = 1'b0;
    end else if (want_flags[2]) begin
      f_vol = b;
      want_flags[2] = 1'b0;
    end else if (want_flags[3]) begin
      f_cmd = b;
      want_flags[3] = 1'b0;
    end else begin
      f_par = b;
      want_flags = 5'd0;
    end
    cell_busy = (want_flags != 5'd0);
    if (cell_busy) return 1'b0;

    chans = (chan_reg == 0) ? 1 : ((chan_reg > CH_LIMIT) ? CH_LIMIT : int'(chan_reg));
    nrows = (row_reg == 0) ? 1 : ((row_reg > ROW_LIMIT) ? ROW_LIMIT : int'(row_reg));
    last_ch  = (int'(ch_pos) + 1 >= chans);
    last_row = (int'(row_pos) + 1 >= nrows);

    note = (f_note == NOTE_OFF) ? KEY_OFF : f_note;
    if (f_inst == EMPTY) inst = EMPTY;
    else inst = (f_inst >= 8'd1 && f_inst < 8'd100) ? f_inst - 8'd1 : EMPTY;

    lo_v  = f_vol[3:0];
    vclip = (lo_v > 9) ? 9 : lo_v;
    case (f_vol[7:4])
      4'h0:                   vol = f_vol;
      4'h1, 4'h2, 4'h3, 4'h4: vol = f_vol - 8'h10;
      4'h6:                   vol = 8'(vclip + 95);
      4'h7:                   vol = 8'(vclip + 85);
      4'h8:                   vol = 8'(vclip + 75);
      4'h9:                   vol = 8'(vclip + 65);
      4'hB:                   vol = 8'(vclip + 203);
      4'hC:                   vol = 8'(128 + lo_v * 65 / 15);
      4'hF:                   vol = 8'(193 + lo_v * 9 / 15);
      default:                vol = EMPTY;
    endcase
    if (f_vol == EMPTY) vol = EMPTY;

    par = f_par;
    lo  = f_par[3:0];
    hi  = f_par[7:4];
    case (f_cmd)
      FX_ARPEGGIO:     cmd = CMD_J;
      FX_PORTA_UP:     cmd = CMD_F;
      FX_PORTA_DOWN:   cmd = CMD_E;
      FX_TONE_PORTA:   cmd = CMD_G;
      FX_VIBRATO:      cmd = CMD_H;
      FX_TONE_VOL:     cmd = CMD_L;
      FX_VIB_VOL:      cmd = CMD_K;
      FX_TREMOLO:      cmd = CMD_R;
      FX_PANNING:      cmd = CMD_X;
      FX_OFFSET:       cmd = CMD_O;
      FX_VOL_SLIDE:    cmd = CMD_D;
      FX_JUMP:         cmd = CMD_B;
      FX_BREAK:        cmd = CMD_C;
      FX_EXTENDED: begin
        cmd = CMD_S;
        case (hi)
          EXT_FINE_UP, EXT_FINE_DOWN, EXT_RETRIGGER, EXT_FINE_VOL_UP, EXT_FINE_VOL_DOWN: begin
            if (lo == 4'd0) begin
              cmd = EMPTY;
              par = 8'd0;
            end else begin
              case (hi)
                EXT_FINE_UP: begin
                  cmd = CMD_F;
                  par = {4'hF, lo};
                end
                EXT_FINE_DOWN: begin
                  cmd = CMD_E;
                  par = {4'hF, lo};
                end
                EXT_RETRIGGER: begin
                  cmd = CMD_Q;
                  par = {4'h0, lo};
                end
                EXT_FINE_VOL_UP: begin
                  cmd = CMD_D;
                  par = {lo, 4'hF};
                end
                default: begin
                  cmd = CMD_D;
                  par = {4'hF, lo};
                end
              endcase
            end
          end
          EXT_ROW_DELAY: par = {4'hB, lo};
          default: ;
        endcase
      end
      FX_SPEED:        cmd = (f_par < 8'd32) ? CMD_A : CMD_T;
      FX_GLOBAL_VOL:   cmd = CMD_V;
      FX_GLOBAL_SLIDE: cmd = CMD_W;
      FX_KEY_OFF: begin
        if (note == EMPTY) note = KEY_OFF;
        cmd = EMPTY;
      end
      FX_PAN_SLIDE:    cmd = CMD_P;
      FX_RETRIGGER:    cmd = CMD_Q;
      FX_TREMOR:       cmd = CMD_I;
      default:         cmd = EMPTY;
    endcase

    c.note        = note;
    c.instrument  = inst;
    c.volume      = vol;
    c.command     = cmd;
    c.parameter_b = par;
    c.channel     = ch_pos;
    c.row         = row_pos;
    c.last        = last_ch && last_row;

    if (last_ch) begin
      ch_pos  = 5'd0;
      row_pos = last_row ? 8'd0 : row_pos + 8'd1;
    end else begin
      ch_pos = ch_pos + 5'd1;
    end
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int exp);
    mismatches++;
    if (mismatches <= MAX_PRINTS)
      $display("%0t mismatch %s: got %0d expected %0d", $time, what, got, exp);
  endtask

  task automatic check_cell(input cell_t got, input cell_t exp);
    if (got.note !== exp.note) report_mismatch("note", int'(got.note), int'(exp.note));
    if (got.instrument !== exp.instrument)
      report_mismatch("instrument", int'(got.instrument), int'(exp.instrument));
    if (got.volume !== exp.volume)
      report_mismatch("volume", int'(got.volume), int'(exp.volume));
    if (got.command !== exp.command)
      report_mismatch("command", int'(got.command), int'(exp.command));
    if (got.parameter_b !== exp.parameter_b)
      report_mismatch("parameter", int'(got.parameter_b), int'(exp.parameter_b));
    if (got.channel !== exp.channel)
      report_mismatch("channel", int'(got.channel), int'(exp.channel));
    if (got.row !== exp.row) report_mismatch("row", int'(got.row), int'(exp.row));
    if (got.last !== exp.last) report_mismatch("last_cell", int'(got.last), int'(exp.last));
  endtask

  // cell side: check each transfer, then pick the next ready
  always @(posedge clk) begin
    cell_t got;
    if (!rst && cell_if.valid && cell_if.ready) begin
      got.note        = cell_if.note_out;
      got.instrument  = cell_if.instrument_out;
      got.volume      = cell_if.volume_out;
      got.command     = cell_if.command_out;
      got.parameter_b = cell_if.parameter_out;
      got.channel     = cell_if.channel_index;
      got.row         = cell_if.row_index;
      got.last        = cell_if.last_cell;
      cells_seen++;
      if (got.last === 1'b1) pattern_ends++;
      if (cells_due.size() == 0) report_mismatch("cell with none due", int'(got.note), -1);
      else check_cell(got, cells_due.pop_front());
    end
    cell_if.ready <= ($urandom_range(99) >= stall_pct);
  end

  task automatic send_byte(input logic [7:0] b, input bit typed, input cell_t typed_cell);
    bit taken;
    cell_t c;
    while ($urandom_range(99) < idle_pct) begin
      pattern_if.valid <= 1'b0;
      @(posedge clk);
    end
    pattern_if.valid       <= 1'b1;
    pattern_if.stream_byte <= b;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk);
      taken = pattern_if.ready;
    end
    bytes_sent++;
    if (unpack_byte(b, c)) cells_due = {cells_due, (typed ? typed_cell : c)};
  endtask

  task automatic feed(input logic [7:0] b);
    send_byte(b, 1'b0, '0);
  endtask

  task automatic add_byte(input logic [7:0] b);
    dir_step_t s;
    s.b = b;
    s.typed = 1'b0;
    s.want = '0;
    dir_plan = {dir_plan, s};
  endtask

  // typed rows sit on row 0 of a fresh pattern, never the last cell
  task automatic add_cell(input logic [7:0] b, input logic [7:0] note, input logic [7:0] inst,
                          input logic [7:0] vol, input logic [7:0] cmd, input logic [7:0] par,
                          input logic [4:0] ch);
    dir_step_t s;
    s.b = b;
    s.typed = 1'b1;
    s.want = '{note, inst, vol, cmd, par, ch, 8'd0, 1'b0};
    dir_plan = {dir_plan, s};
  endtask

  task automatic wait_idle();
    while (cells_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(input logic [8:0] chans, input logic [8:0] nrows);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_CHANNELS;
    cfg_data  <= chans;
    @(posedge clk);
    chan_reg = chans[5:0];
    cfg_index <= CFG_ROWS;
    cfg_data  <= nrows;
    @(posedge clk);
    row_reg = nrows;
    cfg_we <= 1'b0;
  endtask

  // mostly well-formed cells with random content, some loose bytes
  task automatic random_cell();
    logic [4:0] flags;
    logic [7:0] fx;
    int r;
    fx = EMPTY;
    if ($urandom_range(99) < 20) begin
      feed(8'($urandom_range(255)));
      return;
    end
    if ($urandom_range(3) == 0) begin
      feed(($urandom_range(7) == 0) ? NOTE_OFF : 8'($urandom_range(127)));
      flags = 5'h1E;
    end else begin
      flags = 5'($urandom);
      feed({1'b1, 2'($urandom), flags});
    end
    if (flags[0]) begin
      r = $urandom_range(7);
      feed((r == 0) ? NOTE_OFF : (r == 1) ? EMPTY : 8'($urandom_range(255)));
    end
    if (flags[1]) begin
      r = $urandom_range(7);
      if (r == 0) feed(8'd0);
      else if (r == 1) feed(EMPTY);
      else if (r == 2) feed(8'($urandom_range(254, 100)));
      else feed(8'($urandom_range(99, 1)));
    end
    if (flags[2]) feed(($urandom_range(7) == 0) ? EMPTY : 8'($urandom_range(255)));
    if (flags[3]) begin
      r = $urandom_range(9);
      if (r == 0) fx = 8'($urandom_range(255));
      else if (r == 1) fx = FX_SET_VOLUME;
      else fx = fx_codes[$urandom_range(20)];
      feed(fx);
    end
    if (flags[4]) begin
      if (fx == FX_EXTENDED)
        feed({($urandom_range(4) == 0) ? 4'($urandom) : ext_codes[$urandom_range(5)],
              ($urandom_range(3) == 0) ? 4'h0 : 4'($urandom)});
      else
        feed(8'($urandom_range(255)));
    end
  endtask

  initial begin
    int start;
    rst                    <= 1'b1;
    cfg_we                 <= 1'b0;
    cfg_index              <= CFG_CHANNELS;
    cfg_data               <= 9'd0;
    pattern_if.valid       <= 1'b0;
    pattern_if.stream_byte <= 8'd0;

    // empty lead; note lead with lowest instrument, set-volume effect
    add_cell(8'h80, EMPTY, EMPTY, EMPTY, EMPTY, 8'h00, 5'd0);
    add_byte(8'h00);
    add_byte(8'h01);
    add_byte(8'h10);
    add_byte(FX_SET_VOLUME);
    add_cell(8'hFF, 8'h00, 8'h00, 8'h00, EMPTY, 8'hFF, 5'd1);
    // all fields: key-off note, top instrument, empty volume, key-off effect
    add_byte(8'h9F);
    add_byte(NOTE_OFF);
    add_byte(8'd99);
    add_byte(8'hFF);
    add_byte(FX_KEY_OFF);
    add_cell(8'h00, KEY_OFF, 8'd98, EMPTY, EMPTY, 8'h00, 5'd2);
    // top note, empty instrument, full panning, retrigger with zero count
    add_byte(8'h7F);
    add_byte(8'hFF);
    add_byte(8'hCF);
    add_byte(FX_EXTENDED);
    add_cell(8'h90, 8'h7F, EMPTY, 8'd193, EMPTY, 8'h00, 5'd3);
    // key-off effect on an empty note
    add_byte(8'h98);
    add_byte(FX_KEY_OFF);
    add_cell(8'h33, KEY_OFF, EMPTY, EMPTY, EMPTY, 8'h33, 5'd4);
    // second-highest portamento volume, speed at its limit
    add_byte(8'h9C);
    add_byte(8'hFE);
    add_byte(FX_SPEED);
    add_cell(8'h1F, EMPTY, EMPTY, 8'd201, CMD_A, 8'h1F, 5'd5);
    // raw empty command byte
    add_byte(8'h88);
    add_cell(8'hFF, EMPTY, EMPTY, EMPTY, EMPTY, 8'h00, 5'd6);

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_plan[i]) send_byte(dir_plan[i].b, dir_plan[i].typed, dir_plan[i].want);

    for (int p = 0; p < PHASES; p++) begin
      pattern_if.valid <= 1'b0;
      wait_idle();
      set_config(ph_chans[p], ph_rows[p]);
      idle_pct  = ph_idle[p];
      stall_pct = ph_stall[p];
      start = bytes_sent;
      while (bytes_sent - start < PHASE_BYTES) random_cell();
      while (cell_busy) feed(8'($urandom_range(255)));
    end
    pattern_if.valid <= 1'b0;

    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("%0d bytes in, %0d cells checked (%0d pattern ends) over %0d settings",
             bytes_sent, cells_seen, pattern_ends, PHASES + 1);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
